/* src/fpcm_pkg.sv */
// ----------------------------------------------------------------------------
// fpcm_pkg
// Shared binary32 constants and classification helpers for the complex
// multiply datapath.
// ----------------------------------------------------------------------------
package fpcm_pkg;

	localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
	localparam logic [31:0] EXP_MASK    = 32'h7F80_0000;
	localparam logic [31:0] MAN_MASK    = 32'h007F_FFFF;
	localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
	localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
	localparam logic [31:0] ABS_MASK    = 32'h7FFF_FFFF;

	typedef logic [31:0] fp32_t;

	function automatic logic is_nan(input fp32_t x);
		is_nan = ((x & EXP_MASK) == EXP_MASK) && ((x & MAN_MASK) != 32'd0);
	endfunction

	function automatic logic is_inf(input fp32_t x);
		is_inf = (x & ABS_MASK) == EXP_MASK;
	endfunction

	function automatic logic is_zero(input fp32_t x);
		is_zero = (x & ABS_MASK) == 32'd0;
	endfunction

	// denormals read as a zero of the same sign
	function automatic fp32_t daz(input fp32_t x);
		daz = ((x & EXP_MASK) == 32'd0) ? (x & SIGN_BIT) : x;
	endfunction

endpackage

/* src/fpcm_mul.sv */
// ----------------------------------------------------------------------------
// fpcm_mul
// Two-stage binary32 multiplier: special-case decode and 24x24 significand
// product, then normalize, round to nearest-even and pack.
// ----------------------------------------------------------------------------
module fpcm_mul (
	input  logic              clk,
	input  logic              ce,
	input  fpcm_pkg::fp32_t   a,
	input  fpcm_pkg::fp32_t   b,
	output fpcm_pkg::fp32_t   p
);

	fpcm_pkg::fp32_t ad, bd, spec_val;
	logic            spec, sgn;

	logic [47:0]     prod_s1;
	logic [8:0]      esum_s1;
	logic            sgn_s1, spec_s1;
	fpcm_pkg::fp32_t spec_val_s1;

	always_comb begin
		ad  = fpcm_pkg::daz(a);
		bd  = fpcm_pkg::daz(b);
		sgn = ad[31] ^ bd[31];
		spec = 1'b1;
		spec_val = 32'd0;
		priority if (fpcm_pkg::is_nan(a)) begin
			spec_val = a | fpcm_pkg::QUIET_BIT;
		end else if (fpcm_pkg::is_nan(b)) begin
			spec_val = b | fpcm_pkg::QUIET_BIT;
		end else if (fpcm_pkg::is_inf(ad) || fpcm_pkg::is_inf(bd)) begin
			if (fpcm_pkg::is_zero(ad) || fpcm_pkg::is_zero(bd))
				spec_val = fpcm_pkg::DEFAULT_NAN;
			else
				spec_val = {sgn, 31'd0} | fpcm_pkg::EXP_MASK;
		end else if (fpcm_pkg::is_zero(ad) || fpcm_pkg::is_zero(bd)) begin
			spec_val = {sgn, 31'd0};
		end else begin
			spec = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			prod_s1     <= {24'd0, 1'b1, ad[22:0]} * {24'd0, 1'b1, bd[22:0]};
			esum_s1     <= {1'b0, ad[30:23]} + {1'b0, bd[30:23]};
			sgn_s1      <= sgn;
			spec_s1     <= spec;
			spec_val_s1 <= spec_val;
		end
	end

	// round: leading one sits at bit 47 or 46
	logic [23:0]        m;
	logic               half, sticky, up, carry;
	logic [24:0]        m25;
	logic signed [10:0] be;
	fpcm_pkg::fp32_t    res;

	always_comb begin
		if (prod_s1[47]) begin
			m      = prod_s1[47:24];
			half   = prod_s1[23];
			sticky = |prod_s1[22:0];
		end else begin
			m      = prod_s1[46:23];
			half   = prod_s1[22];
			sticky = |prod_s1[21:0];
		end
		up    = half && (sticky || m[0]);
		m25   = {1'b0, m} + {24'd0, up};
		carry = m25[24];
		be    = $signed({2'b00, esum_s1}) - 11'sd127 + $signed({10'd0, prod_s1[47]})
		        + $signed({10'd0, carry});
		if (spec_s1)
			res = spec_val_s1;
		else if (be >= 11'sd255)
			res = {sgn_s1, 31'd0} | fpcm_pkg::EXP_MASK;
		else if (be <= 11'sd0)
			res = {sgn_s1, 31'd0};
		else
			res = {sgn_s1, be[7:0], carry ? 23'd0 : m25[22:0]};
	end

	always_ff @(posedge clk) begin
		if (ce)
			p <= res;
	end

endmodule

/* src/fpcm_add.sv */
// ----------------------------------------------------------------------------
// fpcm_add
// Four-stage binary32 adder/subtractor: swap and align, add, leading-zero
// count, normalize/round/pack. Guard, round and sticky bits keep rounding exact.
// ----------------------------------------------------------------------------
module fpcm_add (
	input  logic              clk,
	input  logic              ce,
	input  fpcm_pkg::fp32_t   a,
	input  fpcm_pkg::fp32_t   b,
	input  logic              sub,
	output fpcm_pkg::fp32_t   y
);

	// stage 3: specials, swap, align
	fpcm_pkg::fp32_t be_raw, ad, bd, x, z, spec_val;
	logic            spec;
	logic [7:0]      d;
	logic [53:0]     sh;
	logic [26:0]     bal;

	always_comb begin
		be_raw = (sub && !fpcm_pkg::is_nan(b)) ? (b ^ fpcm_pkg::SIGN_BIT) : b;
		ad = fpcm_pkg::daz(a);
		bd = fpcm_pkg::daz(be_raw);
		spec = 1'b1;
		spec_val = 32'd0;
		priority if (fpcm_pkg::is_nan(a)) begin
			spec_val = a | fpcm_pkg::QUIET_BIT;
		end else if (fpcm_pkg::is_nan(be_raw)) begin
			spec_val = be_raw | fpcm_pkg::QUIET_BIT;
		end else if (fpcm_pkg::is_inf(ad)) begin
			spec_val = (fpcm_pkg::is_inf(bd) && (ad[31] != bd[31])) ?
			           fpcm_pkg::DEFAULT_NAN : ad;
		end else if (fpcm_pkg::is_inf(bd)) begin
			spec_val = bd;
		end else if (fpcm_pkg::is_zero(ad) && fpcm_pkg::is_zero(bd)) begin
			spec_val = {ad[31] & bd[31], 31'd0};
		end else if (fpcm_pkg::is_zero(ad)) begin
			spec_val = bd;
		end else if (fpcm_pkg::is_zero(bd)) begin
			spec_val = ad;
		end else begin
			spec = 1'b0;
		end
		if ((ad & fpcm_pkg::ABS_MASK) < (bd & fpcm_pkg::ABS_MASK)) begin
			x = bd;
			z = ad;
		end else begin
			x = ad;
			z = bd;
		end
		d  = x[30:23] - z[30:23];
		sh = {1'b1, z[22:0], 3'b000, 27'd0} >> d;
		if (d >= 8'd27)
			bal = 27'd1;
		else
			bal = {sh[53:28], sh[27] | (|sh[26:0])};
	end

	logic [26:0]     a_s3, b_s3;
	logic [7:0]      ea_s3;
	logic            sgn_s3, op_sub_s3, spec_s3;
	fpcm_pkg::fp32_t spec_val_s3;

	always_ff @(posedge clk) begin
		if (ce) begin
			a_s3        <= {1'b1, x[22:0], 3'b000};
			b_s3        <= bal;
			ea_s3       <= x[30:23];
			sgn_s3      <= x[31];
			op_sub_s3   <= x[31] ^ z[31];
			spec_s3     <= spec;
			spec_val_s3 <= spec_val;
		end
	end

	// stage 4: add or subtract; exact cancellation gives +0
	logic [27:0]     sum_s4;
	logic [7:0]      ea_s4;
	logic            sgn_s4, spec_s4;
	fpcm_pkg::fp32_t spec_val_s4;

	always_ff @(posedge clk) begin
		if (ce) begin
			sum_s4      <= op_sub_s3 ? ({1'b0, a_s3} - {1'b0, b_s3})
			                         : ({1'b0, a_s3} + {1'b0, b_s3});
			ea_s4       <= ea_s3;
			sgn_s4      <= sgn_s3;
			spec_s4     <= spec_s3 || (op_sub_s3 && (a_s3 == b_s3));
			spec_val_s4 <= spec_s3 ? spec_val_s3 : 32'd0;
		end
	end

	// stage 5: leading-zero count
	logic [4:0] lz;

	always_comb begin
		lz = 5'd0;
		for (int i = 0; i < 28; i++) begin
			if (sum_s4[i])
				lz = 5'(27 - i);
		end
	end

	logic [27:0]     sum_s5;
	logic [4:0]      lz_s5;
	logic [7:0]      ea_s5;
	logic            sgn_s5, spec_s5;
	fpcm_pkg::fp32_t spec_val_s5;

	always_ff @(posedge clk) begin
		if (ce) begin
			sum_s5      <= sum_s4;
			lz_s5       <= lz;
			ea_s5       <= ea_s4;
			sgn_s5      <= sgn_s4;
			spec_s5     <= spec_s4;
			spec_val_s5 <= spec_val_s4;
		end
	end

	// stage 6: normalize, round, pack
	logic [27:0]        n;
	logic               up, carry;
	logic [24:0]        m25;
	logic signed [10:0] bexp;
	fpcm_pkg::fp32_t    res;

	always_comb begin
		n     = sum_s5 << lz_s5;
		up    = n[3] && ((|n[2:0]) || n[4]);
		m25   = {1'b0, n[27:4]} + {24'd0, up};
		carry = m25[24];
		bexp  = $signed({3'b000, ea_s5}) + 11'sd1 - $signed({6'd0, lz_s5})
		        + $signed({10'd0, carry});
		if (spec_s5)
			res = spec_val_s5;
		else if (bexp >= 11'sd255)
			res = {sgn_s5, 31'd0} | fpcm_pkg::EXP_MASK;
		else if (bexp <= 11'sd0)
			res = {sgn_s5, 31'd0};
		else
			res = {sgn_s5, bexp[7:0], carry ? 23'd0 : m25[22:0]};
	end

	always_ff @(posedge clk) begin
		if (ce)
			y <= res;
	end

endmodule

/* src/fp32_complex_multiply_core.sv */
// ----------------------------------------------------------------------------
// fp32_complex_multiply_core
// Single-precision complex multiply, (a_re + j a_im) * (b_re + j b_im).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid/in_ready with a_re, a_im, b_re, b_im as binary32
//   bit patterns. Output channel: out_valid/out_ready with prod_re, prod_im.
//   One transfer in gives exactly one transfer out, in order.
//   prod_re = a_re*b_re - a_im*b_im, prod_im = a_re*b_im + a_im*b_re; every
//   product and sum rounds to nearest-even, denormals flush to signed zero.
//   Pipeline: six register stages (2 multiplier, 4 adder); the first loads at
//   the input transfer edge and the last adder stage is the output register.
//   Throughput: one transfer per cycle while out_ready is high.
//   Stall: when out_valid is high and out_ready low, the whole pipeline holds
//   (in_ready drops) and nothing is lost or repeated; in_ready is high
//   whenever the output register is empty or being drained.
//   Reset (arst_n low, asynchronous) empties all stages; no clearing pass.
// ----------------------------------------------------------------------------
module fp32_complex_multiply_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] a_re,
	input  logic [31:0] a_im,
	input  logic [31:0] b_re,
	input  logic [31:0] b_im,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] prod_re,
	output logic [31:0] prod_im
);

	// global advance: every stage moves when the output is free or taken
	logic ce;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	assign ce        = !v_s6 || out_ready;
	assign in_ready  = ce;
	assign out_valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (ce) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// four products, two stages each
	fpcm_pkg::fp32_t p_rr, p_ii, p_ri, p_ir;

	fpcm_mul u_mul_rr (.clk(clk), .ce(ce), .a(a_re), .b(b_re), .p(p_rr));
	fpcm_mul u_mul_ii (.clk(clk), .ce(ce), .a(a_im), .b(b_im), .p(p_ii));
	fpcm_mul u_mul_ri (.clk(clk), .ce(ce), .a(a_re), .b(b_im), .p(p_ri));
	fpcm_mul u_mul_ir (.clk(clk), .ce(ce), .a(a_im), .b(b_re), .p(p_ir));

	// real part subtracts; a NaN subtrahend keeps its sign
	fpcm_add u_add_re (.clk(clk), .ce(ce), .a(p_rr), .b(p_ii), .sub(1'b1), .y(prod_re));
	fpcm_add u_add_im (.clk(clk), .ce(ce), .a(p_ri), .b(p_ir), .sub(1'b0), .y(prod_im));

endmodule

/* src/fpcm_chk.sv */
// ----------------------------------------------------------------------------
// fpcm_chk
// Port-level checks for the complex multiply core, bound to the top level.
// ----------------------------------------------------------------------------
module fpcm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [31:0] a_re,
	input logic [31:0] a_im,
	input logic [31:0] b_re,
	input logic [31:0] b_im,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] prod_re,
	input logic [31:0] prod_im
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(prod_re) && $stable(prod_im))
		else $error("stalled result changed");

	// input side is open exactly when the output register can move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow output stall");

	// a transfer reaches out_valid when out_ready is high at each edge that moves it through the later stages
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		$past(in_valid && in_ready, 6) && $past(arst_n, 6) && $past(out_ready, 1)
		&& $past(out_ready, 2) && $past(out_ready, 3) && $past(out_ready, 4)
		&& $past(out_ready, 5) |-> out_valid)
		else $error("result missing after pipeline latency");

endmodule

bind fp32_complex_multiply_core fpcm_chk u_fpcm_chk (.*);

/* tb/sv/fpcm_scoreboard.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpcm_scoreboard
// Bit-exact prediction of the binary32 complex product and an in-order queue
// of expected products checked against each output transfer.
// ----------------------------------------------------------------------------
class fpcm_scoreboard;

	typedef struct packed {
		logic [31:0] re;
		logic [31:0] im;
	} cplx_t;

	cplx_t pending[$];
	int    mismatches;
	int    checked;

	function new();
		mismatches = 0;
		checked    = 0;
	endfunction

	static function bit nan32(logic [31:0] x);
		return x[30:23] == 8'hFF && x[22:0] != 0;
	endfunction

	static function bit inf32(logic [31:0] x);
		return x[30:0] == 31'h7F80_0000;
	endfunction

	static function logic [31:0] flush(logic [31:0] x);
		return x[30:23] == 0 ? {x[31], 31'd0} : x;
	endfunction

	// sig * 2^e, sig nonzero, rounded to nearest-even
	static function logic [31:0] pack_rounded(bit s, int e, logic [63:0] sig);
		int          k;
		int          sh;
		int          be;
		logic [63:0] m;
		logic [63:0] rem;
		logic [63:0] half;
		k = 63;
		while (!sig[k]) k--;
		if (k > 23) begin
			sh   = k - 23;
			rem  = sig & ((64'd1 << sh) - 1);
			half = 64'd1 << (sh - 1);
			m    = sig >> sh;
			if (rem > half || (rem == half && m[0])) m++;
			if (m == (64'd1 << 24)) begin
				m = m >> 1;
				k++;
			end
		end else begin
			m = sig << (23 - k);
		end
		be = e + k + 127;
		if (be >= 255) return {s, 31'h7F80_0000};
		if (be <= 0) return {s, 31'd0};
		return {s, be[7:0], m[22:0]};
	endfunction

	static function logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
		bit s;
		if (nan32(a)) return a | fpcm_pkg::QUIET_BIT;
		if (nan32(b)) return b | fpcm_pkg::QUIET_BIT;
		a = flush(a);
		b = flush(b);
		s = a[31] ^ b[31];
		if (inf32(a) || inf32(b)) begin
			if (a[30:0] == 0 || b[30:0] == 0) return fpcm_pkg::DEFAULT_NAN;
			return {s, 31'h7F80_0000};
		end
		if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
		return pack_rounded(s, int'(a[30:23]) + int'(b[30:23]) - 300,
			64'({1'b1, a[22:0]}) * 64'({1'b1, b[22:0]}));
	endfunction

	static function logic [31:0] add32(logic [31:0] a, logic [31:0] b);
		logic [31:0] t;
		logic [63:0] big;
		logic [63:0] lil;
		int          d;
		int          e;
		if (nan32(a)) return a | fpcm_pkg::QUIET_BIT;
		if (nan32(b)) return b | fpcm_pkg::QUIET_BIT;
		a = flush(a);
		b = flush(b);
		if (inf32(a)) begin
			if (inf32(b) && a[31] != b[31]) return fpcm_pkg::DEFAULT_NAN;
			return a;
		end
		if (inf32(b)) return b;
		if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
		if (a[30:0] == 0) return b;
		if (b[30:0] == 0) return a;
		if (a[30:0] < b[30:0]) begin
			t = a;
			a = b;
			b = t;
		end
		d = int'(a[30:23]) - int'(b[30:23]);
		if (d < 40) begin
			big = 64'({1'b1, a[22:0]}) << d;
			lil = 64'({1'b1, b[22:0]});
			e   = int'(b[30:23]) - 150;
		end else begin
			// far smaller addend only sets sticky
			big = 64'({1'b1, a[22:0]}) << 3;
			lil = 64'd1;
			e   = int'(a[30:23]) - 153;
		end
		if (a[31] == b[31]) return pack_rounded(a[31], e, big + lil);
		if (big == lil) return 32'd0;
		return pack_rounded(a[31], e, big - lil);
	endfunction

	static function logic [31:0] sub32(logic [31:0] a, logic [31:0] b);
		if (!nan32(b)) b[31] = ~b[31];
		return add32(a, b);
	endfunction

	function void note_operands(logic [31:0] ar, logic [31:0] ai,
			logic [31:0] br, logic [31:0] bi);
		cplx_t p;
		p.re = sub32(mul32(ar, br), mul32(ai, bi));
		p.im = add32(mul32(ar, bi), mul32(ai, br));
		pending.push_back(p);
	endfunction

	function void report(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		$display("mismatch #%0d %s: got %h want %h", checked, what, got, want);
	endfunction

	function void check_product(logic [31:0] re, logic [31:0] im);
		cplx_t p;
		if (pending.size() == 0) begin
			report("prod_re, nothing pending", re, 'x);
			return;
		end
		p = pending.pop_front();
		if (re !== p.re) report("prod_re", re, p.re);
		if (im !== p.im) report("prod_im", im, p.im);
		checked++;
	endfunction

endclass

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Directed special values then random operands (mostly finite, some NaN, inf,
// zero and denormal) through the complex multiply, under four idling phases.
// ----------------------------------------------------------------------------
module testbench;

	localparam int WATCHDOG = 2000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] a_re, a_im, b_re, b_im;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] prod_re, prod_im;

	fpcm_scoreboard sb;
	int sender_idle_pct;   // chance of a gap before each transfer
	int recv_stall_pct;    // chance out_ready is low in a cycle
	int idle_cycles;
	bit timed_out;

	fp32_complex_multiply_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.out_valid(out_valid), .out_ready(out_ready),
		.prod_re(prod_re), .prod_im(prod_im)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Transfer bookkeeping: sampled at the edge, before NBA updates land.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_operands(a_re, a_im, b_re, b_im);
			if (out_valid && out_ready)
				sb.check_product(prod_re, prod_im);
		end
	end

	// Receiver: random stall per cycle, held off during reset.
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG && !timed_out) begin
			timed_out = 1'b1;
			$display("watchdog expired, %0d products pending", sb.pending.size());
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Random binary32 pattern biased toward the interesting classes.
	function automatic logic [31:0] rand_fp(bit noisy);
		logic [31:0] x;
		int          pick;
		x    = $urandom;
		pick = $urandom_range(99);
		if (!noisy || pick >= 30) begin
			// finite normal, exponent near the middle so products cancel/round
			x[30:23] = 8'($urandom_range(90, 164));
		end else if (pick < 5) x[30:0] = 31'h7F80_0000;              // inf
		else if (pick < 10) x[30:23] = 8'hFF;                        // NaN (or inf)
		else if (pick < 15) x[30:0] = 31'd0;                         // zero
		else if (pick < 20) x[30:23] = 8'h00;                        // denormal
		else if (pick < 25) x[30:23] = 8'($urandom_range(1, 12));    // near underflow
		else x[30:23] = 8'($urandom_range(240, 254));                // near overflow
		return x;
	endfunction

	// One input transfer: optional gap, then hold valid until accepted.
	task automatic send(logic [31:0] ar, logic [31:0] ai, logic [31:0] br,
			logic [31:0] bi);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		a_re     <= ar;
		a_im     <= ai;
		b_re     <= br;
		b_im     <= bi;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic run_phase(int idle_pct, int stall_pct, int count);
		bit noisy;
		sender_idle_pct = idle_pct;
		recv_stall_pct  = stall_pct;
		repeat (count) begin
			noisy = ($urandom_range(99) < 35);
			send(rand_fp(noisy), rand_fp(noisy), rand_fp(noisy), rand_fp(noisy));
		end
	endtask

	initial begin
		sb              = new();
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		a_re            = '0;
		a_im            = '0;
		b_re            = '0;
		b_im            = '0;
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes and each special case
		send(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(32'h7F80_0001, 32'hFFC0_1234, 32'h3F80_0000, 32'h7FA0_0000); // NaN order
		send(32'h3F80_0000, 32'h3F80_0000, 32'h7F80_0001, 32'hFF80_0005); // NaN subtrahend
		send(32'h7F80_0000, 32'h3F80_0000, 32'h0000_0000, 32'h3F80_0000); // inf * 0
		send(32'h7F80_0000, 32'h7F80_0000, 32'h3F80_0000, 32'hBF80_0000); // inf - inf
		send(32'h7F80_0000, 32'hFF80_0000, 32'h3F80_0000, 32'h3F80_0000);
		send(32'h0000_0001, 32'h807F_FFFF, 32'h3F80_0000, 32'h4000_0000); // denormal in
		send(32'h0080_0000, 32'h0080_0000, 32'h3F00_0000, 32'h3F00_0000); // flush out
		send(32'h0080_0001, 32'h0000_0000, 32'h3F7F_FFFF, 32'h0000_0000); // rounds down
		send(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF); // overflow
		send(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000); // exact cancel
		send(32'h4049_0FDB, 32'hC02D_F854, 32'h3F35_04F3, 32'hBF35_04F3);
		send(32'h3F80_0001, 32'h3F80_0000, 32'h3F80_0001, 32'h3F80_0000); // product rounds down
		send(32'h7F00_0000, 32'h0080_0000, 32'h3F80_0000, 32'h3F80_0000); // far apart
		send(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC);
		send(32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000);

		run_phase(0, 0, 150);
		run_phase(62, 0, 150);
		run_phase(0, 62, 150);
		run_phase(33, 33, 150);
		in_valid <= 1'b0;
		recv_stall_pct = 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);

		$display("covered %0d products: special values, random operands, four idle phases",
			sb.checked);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

/* filelist.f */
src/fpcm_pkg.sv
src/fpcm_mul.sv
src/fpcm_add.sv
src/fp32_complex_multiply_core.sv
src/fpcm_chk.sv
tb/sv/fpcm_scoreboard.sv
tb/sv/testbench.sv
